// ----- src/crts_pkg.sv -----
// Shared types and constants of the call/return trace stack.
package crts_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] cur_pc;
        logic [31:0] jump_target;
        logic [31:0] inst_word;
        logic [31:0] entry_addr;
    } item_t;

    typedef struct packed {
        logic        is_return;
        logic [31:0] event_pc;
        logic [6:0]  nest_depth;
        logic [4:0]  func_index;
        logic [31:0] target_addr;
        logic [31:0] calls_so_far;
        logic [1:0]  stack_fault;
    } report_t;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_JUMP   = 2'd2;

    localparam logic [31:0] RET_ENCODING = 32'h0000_8067;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_PUSH      = 2'd1;
    localparam logic [1:0] FAULT_UNMATCHED = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_CALL,
        CMD_RET
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] pc;
        logic [31:0] addr;
        logic [31:0] ret_addr;
    } cmd_t;

endpackage

// ----- src/crts_front.sv -----
// Front end: accepts trace items, classifies them and queues commands for the back end.
module crts_front
    import crts_pkg::*;
#(
    parameter int INSTR_BYTES = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  cmd_valid,
    input  logic  cmd_take,
    output cmd_t  cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       keep;
    logic       wr_en;
    logic       rd_en;

    always_comb
    begin
        keep         = 1'b0;
        cls.kind     = CMD_CLEAR;
        cls.pc       = item.cur_pc;
        cls.addr     = item.jump_target;
        cls.ret_addr = item.cur_pc + 32'(INSTR_BYTES);
        case (item.opcode)
            OP_CLEAR:
            begin
                keep     = 1'b1;
                cls.kind = CMD_CLEAR;
            end
            OP_APPEND:
            begin
                keep     = 1'b1;
                cls.kind = CMD_APPEND;
                cls.addr = item.entry_addr;
            end
            OP_JUMP:
            begin
                keep     = 1'b1;
                cls.kind = (item.inst_word == RET_ENCODING) ? CMD_RET : CMD_CALL;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full && keep;
    assign rd_en     = cmd_valid && cmd_take;

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- src/crts_back.sv -----
// Back end: function table, shadow return stack, scan sequencer and result register.
module crts_back
    import crts_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int STACK_DEPTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_take,
    input  cmd_t    cmd,
    output logic    empty,
    input  logic    pop,
    output report_t report
);

    localparam int TIW = $clog2(TABLE_DEPTH);
    localparam int ECW = $clog2(TABLE_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SDW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TREAD,
        S_TCMP,
        S_SREAD,
        S_SCMP
    } state_t;

    state_t         state_reg, state_next;
    logic [ECW-1:0] entry_count_reg, entry_count_next;
    logic [SDW-1:0] depth_reg, depth_next;
    logic [31:0]    call_count_reg, call_count_next;
    logic [ECW-1:0] tidx_reg, tidx_next;
    logic [SDW-1:0] sidx_reg, sidx_next;
    cmd_t           cur_reg, cur_next;
    logic           out_valid_reg, out_valid_next;
    report_t        report_reg, report_next;

    logic [31:0]    tbl_mem [TABLE_DEPTH];
    logic [31:0]    stk_mem [STACK_DEPTH];
    logic [31:0]    tbl_rd_reg;
    logic [31:0]    stk_rd_reg;
    logic           tbl_we;
    logic           stk_we;
    logic [SDW-1:0] sidx_m1;
    logic           slot_free;
    logic           has_room;

    assign sidx_m1   = sidx_reg - SDW'(1);
    assign slot_free = !out_valid_reg || pop;
    assign has_room  = (depth_reg < SDW'(STACK_DEPTH));
    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid &&
                       (cmd.kind == CMD_CLEAR || cmd.kind == CMD_APPEND || slot_free);
    assign empty     = !out_valid_reg;
    assign report    = report_reg;

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        depth_next       = depth_reg;
        call_count_next  = call_count_reg;
        tidx_next        = tidx_reg;
        sidx_next        = sidx_reg;
        cur_next         = cur_reg;
        out_valid_next   = (out_valid_reg && pop) ? 1'b0 : out_valid_reg;
        report_next      = report_reg;
        tbl_we           = 1'b0;
        stk_we           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    cur_next = cmd;
                    case (cmd.kind)
                        CMD_CLEAR:
                        begin
                            entry_count_next = '0;
                            depth_next       = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (entry_count_reg < ECW'(TABLE_DEPTH))
                            begin
                                tbl_we           = 1'b1;
                                entry_count_next = entry_count_reg + ECW'(1);
                            end
                        end
                        CMD_CALL:
                        begin
                            tidx_next  = '0;
                            state_next = S_TREAD;
                        end
                        CMD_RET:
                        begin
                            sidx_next  = depth_reg;
                            state_next = S_SREAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TREAD:
            begin
                state_next = (tidx_reg == entry_count_reg) ? S_IDLE : S_TCMP;
            end
            S_TCMP:
            begin
                if (tbl_rd_reg == cur_reg.addr)
                begin
                    report_next.is_return    = 1'b0;
                    report_next.event_pc     = cur_reg.pc;
                    report_next.nest_depth   = 7'(depth_reg);
                    report_next.func_index   = 5'(tidx_reg);
                    report_next.target_addr  = tbl_rd_reg;
                    report_next.calls_so_far = call_count_reg;
                    report_next.stack_fault  = has_room ? FAULT_NONE : FAULT_PUSH;
                    out_valid_next           = 1'b1;
                    if (has_room)
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + SDW'(1);
                    end
                    call_count_next = call_count_reg + 32'd1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    tidx_next  = tidx_reg + ECW'(1);
                    state_next = S_TREAD;
                end
            end
            S_SREAD:
            begin
                if (sidx_reg == '0)
                begin
                    report_next.is_return    = 1'b1;
                    report_next.event_pc     = cur_reg.pc;
                    report_next.nest_depth   = (depth_reg == '0) ? 7'd0
                                               : 7'(depth_reg - SDW'(1));
                    report_next.func_index   = 5'd0;
                    report_next.target_addr  = cur_reg.addr;
                    report_next.calls_so_far = call_count_reg;
                    report_next.stack_fault  = FAULT_UNMATCHED;
                    out_valid_next           = 1'b1;
                    depth_next               = '0;
                    state_next               = S_IDLE;
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (stk_rd_reg == cur_reg.addr)
                begin
                    report_next.is_return    = 1'b1;
                    report_next.event_pc     = cur_reg.pc;
                    report_next.nest_depth   = 7'(depth_reg - SDW'(1));
                    report_next.func_index   = 5'd0;
                    report_next.target_addr  = cur_reg.addr;
                    report_next.calls_so_far = call_count_reg;
                    report_next.stack_fault  = FAULT_NONE;
                    out_valid_next           = 1'b1;
                    depth_next               = sidx_m1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    sidx_next  = sidx_m1;
                    state_next = S_SREAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            depth_reg       <= '0;
            call_count_reg  <= '0;
            tidx_reg        <= '0;
            sidx_reg        <= '0;
            cur_reg         <= '0;
            out_valid_reg   <= 1'b0;
            report_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            depth_reg       <= depth_next;
            call_count_reg  <= call_count_next;
            tidx_reg        <= tidx_next;
            sidx_reg        <= sidx_next;
            cur_reg         <= cur_next;
            out_valid_reg   <= out_valid_next;
            report_reg      <= report_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[entry_count_reg[TIW-1:0]] <= cmd.addr;
        end
        tbl_rd_reg <= tbl_mem[tidx_reg[TIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[depth_reg[SIW-1:0]] <= cur_reg.ret_addr;
        end
        stk_rd_reg <= stk_mem[sidx_m1[SIW-1:0]];
    end

endmodule

// ----- src/call_return_trace_stack.sv -----
// Top level of the call/return trace stack: front end, command queue and back end.
//
// Both sides behave as queues: an item is taken on push while full is low, a report is
// taken on pop while empty is low. The front end holds up to two classified commands, so
// items keep arriving while the back end scans or a report waits to be popped. Unused
// opcodes are dropped by the front end and never reach the back end. Clear and append
// are carried out as they are taken. A call that hits compares the table entries up to
// and including the first match, one read of the table memory per compare; a call that
// misses compares every loaded entry and gives no report. A return that matches scans
// the stack from the top down to and including the match, popping those entries, with
// one read of the stack memory per compare; a return that matches nothing scans the
// whole stack. A call or return waits in the queue while an unpopped report is still
// held.
module call_return_trace_stack
    import crts_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int STACK_DEPTH = 64,
    parameter int INSTR_BYTES = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output report_t report
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    crts_front #(
        .INSTR_BYTES (INSTR_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    crts_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .report    (report)
    );

endmodule

// ----- src/crts_checker.sv -----
// Port-level checker of the call/return trace stack and its bind.
module crts_checker
    import crts_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input report_t report
);

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(report)))
        else $error("waiting report changed or vanished before transfer");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (report.stack_fault == FAULT_NONE || report.stack_fault == FAULT_PUSH ||
                    report.stack_fault == FAULT_UNMATCHED))
        else $error("undefined stack fault code");

    a_return_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && report.is_return) |->
            (report.func_index == 5'd0 && report.stack_fault != FAULT_PUSH &&
             report.nest_depth < STACK_DEPTH))
        else $error("malformed return report");

    a_call_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !report.is_return) |->
            (report.stack_fault != FAULT_UNMATCHED && report.nest_depth <= STACK_DEPTH))
        else $error("malformed call report");

    a_push_drop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !report.is_return && report.stack_fault == FAULT_PUSH) |->
            (report.nest_depth == 7'(STACK_DEPTH)))
        else $error("dropped push reported below full stack depth");

endmodule

bind call_return_trace_stack crts_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_crts_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .report (report)
);
